[hw/rtl/tsq_pkg.sv]
// types and constants shared by the two-stack queue
`timescale 1ns / 1ps

package tsq_pkg;

   localparam int STACK_DEPTH_DEFAULT = 128;
   localparam int DATA_WIDTH          = 32;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_DEQUEUE = 1'b1;

   typedef struct packed {
      logic                         mode;
      logic signed [DATA_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]                   status;
      logic signed [DATA_WIDTH-1:0] result_value;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_XFER,
      ST_RETRY,
      ST_POP
   } state_type;

endpackage

[hw/rtl/tsq_ram.sv]
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps

module tsq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/two_stack_queue.sv]
// first-in first-out queue built from an inbox stack and an outbox stack
`timescale 1ns / 1ps

// Queue of 32-bit entries held in two stacks of STACK_DEPTH entries, each in
// its own RAM. An enqueue pushes onto the inbox; a dequeue pops the outbox.
// When the outbox runs dry (dequeue) or the inbox is full with an empty outbox
// (enqueue), the whole inbox is copied into the outbox one entry per cycle
// through the RAM read/write ports, which reverses its order. An enqueue,
// full or empty result is registered in the cycle after the item is taken;
// an outbox pop goes through the registered RAM read and ST_POP, a transfer
// through ST_XFER and ST_RETRY. One item is in work at a time; the result
// sits in an output register, and the next item is taken as soon as that
// register is free or being emptied. No clearing pass after reset: the stack
// counts alone say what is stored.
module two_stack_queue #(
   parameter int STACK_DEPTH = tsq_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tsq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tsq_pkg::rsp_type rsp_data
);

   import tsq_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

   state_type       state_ff, state_in;
   logic [CW-1:0]   in_cnt_ff, in_cnt_in;
   logic [CW-1:0]   out_cnt_ff, out_cnt_in;
   req_type         op_ff, op_in;
   logic            rd_pend_ff, rd_pend_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   req_type         cur_op;
   logic            decide;
   logic [CW-1:0]   in_top;
   logic [CW-1:0]   out_top;

   logic                  in_wr_en, in_rd_en, out_wr_en, out_rd_en;
   logic [AW-1:0]         in_wr_addr, in_rd_addr, out_wr_addr, out_rd_addr;
   logic [DATA_WIDTH-1:0] in_rd_data, out_rd_data;

   tsq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STACK_DEPTH)) u_inbox (
      .clock   (clock),
      .wr_en   (in_wr_en),
      .wr_addr (in_wr_addr),
      .wr_data (cur_op.value),
      .rd_en   (in_rd_en),
      .rd_addr (in_rd_addr),
      .rd_data (in_rd_data)
   );

   tsq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STACK_DEPTH)) u_outbox (
      .clock   (clock),
      .wr_en   (out_wr_en),
      .wr_addr (out_wr_addr),
      .wr_data (in_rd_data),
      .rd_en   (out_rd_en),
      .rd_addr (out_rd_addr),
      .rd_data (out_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign cur_op  = (state_ff == ST_IDLE) ? req_data : op_ff;
   assign decide  = (state_ff == ST_RETRY) || (req_valid && req_ready);
   assign in_top  = in_cnt_ff - CW'(1);
   assign out_top = out_cnt_ff - CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_cnt_ff    <= '0;
         out_cnt_ff   <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_cnt_ff    <= in_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      in_cnt_in    = in_cnt_ff;
      out_cnt_in   = out_cnt_ff;
      op_in        = op_ff;
      rd_pend_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      in_wr_en     = 1'b0;
      in_rd_en     = 1'b0;
      out_wr_en    = 1'b0;
      out_rd_en    = 1'b0;
      in_wr_addr   = in_cnt_ff[AW-1:0];
      in_rd_addr   = in_top[AW-1:0];
      out_wr_addr  = out_cnt_ff[AW-1:0];
      out_rd_addr  = out_top[AW-1:0];

      case (state_ff)
         ST_IDLE, ST_RETRY: begin
            if (decide) begin
               op_in    = cur_op;
               state_in = ST_IDLE;
               if (cur_op.mode == MODE_ENQUEUE) begin
                  if (in_cnt_ff < FULL_COUNT) begin
                     in_wr_en     = 1'b1;
                     in_cnt_in    = in_cnt_ff + CW'(1);
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: STATUS_OK, result_value: '0};
                  end else if (out_cnt_ff == '0) begin
                     state_in = ST_XFER;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: STATUS_FULL, result_value: '0};
                  end
               end else begin
                  if (out_cnt_ff != '0) begin
                     out_rd_en  = 1'b1;
                     out_cnt_in = out_top;
                     state_in   = ST_POP;
                  end else if (in_cnt_ff != '0) begin
                     state_in = ST_XFER;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: STATUS_EMPTY, result_value: '0};
                  end
               end
            end
         end
         ST_XFER: begin
            // read the inbox top while the previous read lands in the outbox
            if (in_cnt_ff != '0) begin
               in_rd_en   = 1'b1;
               in_cnt_in  = in_top;
               rd_pend_in = 1'b1;
            end
            if (rd_pend_ff) begin
               out_wr_en  = 1'b1;
               out_cnt_in = out_cnt_ff + CW'(1);
            end
            if (in_cnt_ff == '0 && !rd_pend_ff) begin
               state_in = ST_RETRY;
            end
         end
         ST_POP: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{status: STATUS_OK, result_value: out_rd_data};
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[test/two_stack_queue_checker.sv]
// checker for the two-stack queue: predicts each result and compares it with the block
`timescale 1ns / 1ps

module two_stack_queue_checker #(
   parameter int DEPTH = tsq_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  tsq_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  tsq_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               outstanding,
   output int               read_count,
   output int               drop_count,
   output int               empty_count,
   output int               transfer_count
);

   import tsq_pkg::*;

   logic [DATA_WIDTH-1:0] inbox_mem  [DEPTH];
   logic [DATA_WIDTH-1:0] outbox_mem [DEPTH];
   int                    inbox_fill;
   int                    outbox_fill;
   rsp_type               expected_rsp_q [$];
   int                    printed;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
      read_count     = 0;
      drop_count     = 0;
      empty_count    = 0;
      transfer_count = 0;
      printed        = 0;
      inbox_fill     = 0;
      outbox_fill    = 0;
   end

   // pop the inbox onto the outbox, which reverses the order
   function automatic void move_inbox();
      if (inbox_fill > 0) transfer_count++;
      while (inbox_fill > 0 && outbox_fill < DEPTH) begin
         inbox_fill--;
         outbox_mem[outbox_fill] = inbox_mem[inbox_fill];
         outbox_fill++;
      end
   endfunction

   function automatic rsp_type predict_queue_op(input req_type op);
      rsp_type r;
      r.status       = STATUS_OK;
      r.result_value = '0;
      if (op.mode == MODE_ENQUEUE) begin
         if (inbox_fill >= DEPTH && outbox_fill == 0) move_inbox();
         if (inbox_fill < DEPTH) begin
            inbox_mem[inbox_fill] = op.value;
            inbox_fill++;
         end else begin
            r.status = STATUS_FULL;
            drop_count++;
         end
      end else begin
         if (outbox_fill == 0) move_inbox();
         if (outbox_fill > 0) begin
            outbox_fill--;
            r.result_value = outbox_mem[outbox_fill];
            read_count++;
         end else begin
            r.status = STATUS_EMPTY;
            empty_count++;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (printed < 20) begin
         printed++;
         $display("%0t checker: %s", $realtime, what);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type exp_rsp;
      if (reset) begin
         inbox_fill  = 0;
         outbox_fill = 0;
         expected_rsp_q.delete();
      end else begin
         // the result leaving now belongs to an earlier item, so check it first
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result: status %0d value %0d",
                                         rsp_data.status, rsp_data.result_value));
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               if (rsp_data.status !== exp_rsp.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_data.status, exp_rsp.status));
               if (rsp_data.result_value !== exp_rsp.result_value)
                  report_mismatch($sformatf("result_value %0d, expected %0d",
                                            rsp_data.result_value, exp_rsp.result_value));
            end
         end
         if (req_valid && req_ready) expected_rsp_q.push_back(predict_queue_op(req_data));
      end
      outstanding <= expected_rsp_q.size();
   end

endmodule

[test/two_stack_queue_tb.sv]
// testbench top for the two-stack queue: stimulus, idling and the final verdict
`timescale 1ns / 1ps

module two_stack_queue_tb;
   import tsq_pkg::*;

   localparam int DIRECTED_ITEMS = 23;
   localparam int RANDOM_ITEMS   = 1600;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int mismatch_count;
   int outstanding;
   int read_count;
   int drop_count;
   int empty_count;
   int transfer_count;
   int items_sent = 0;

   two_stack_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   two_stack_queue_checker #(
      .DEPTH (STACK_DEPTH_DEFAULT)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .read_count     (read_count),
      .drop_count     (drop_count),
      .empty_count    (empty_count),
      .transfer_count (transfer_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("watchdog: run did not complete in time");
      $display("two_stack_queue_tb: errors");
      $finish;
   end

   function automatic req_type make_op(input logic mode, input logic [31:0] value);
      req_type op;
      op.mode  = mode;
      op.value = value;
      return op;
   endfunction

   function automatic req_type random_op(input int enq_pct);
      req_type op;
      op.mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQUEUE : MODE_DEQUEUE;
      case ($urandom_range(0, 15))
         0:       op.value = 32'h8000_0000;
         1:       op.value = 32'h7fff_ffff;
         default: op.value = $urandom;
      endcase
      return op;
   endfunction

   // valid stays high from one item to the next unless a gap follows
   task automatic offer(input req_type op);
      req_data  <= op;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic idle_gap(input bit eager);
      int gap;
      int roll;
      roll = $urandom_range(0, 99);
      if (eager || roll < 60) gap = 0;
      else if (roll < 88) gap = $urandom_range(1, 3);
      else if (roll < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(25, 70);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // receiver: random stalls, calm stretches, and one long hold-off
   initial begin
      int  stall_left;
      int  taken;
      int  roll;
      bit  hold_done;
      stall_left = 0;
      taken      = 0;
      hold_done  = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_valid && rsp_ready) taken++;
         if (taken == 500 && !hold_done) begin
            hold_done  = 1'b1;
            stall_left = 300;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            roll = $urandom_range(0, 99);
            if ((taken / 150) % 4 != 3) begin
               if (roll < 15) stall_left = $urandom_range(1, 3);
               else if (roll < 18) stall_left = $urandom_range(10, 40);
            end
         end
         @(posedge clock);
      end
   end

   initial begin
      req_type directed_q [$];
      int      enq_pct;
      int      block_len;
      int      blk;
      bit      eager;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty reads, extreme values, a transfer, and interleaved pushes and pops
      directed_q.push_back(make_op(MODE_DEQUEUE, 32'h0000_0000));
      directed_q.push_back(make_op(MODE_DEQUEUE, 32'h7fff_ffff));
      directed_q.push_back(make_op(MODE_ENQUEUE, 32'h8000_0000));
      directed_q.push_back(make_op(MODE_ENQUEUE, 32'h7fff_ffff));
      directed_q.push_back(make_op(MODE_ENQUEUE, 32'h0000_0000));
      directed_q.push_back(make_op(MODE_ENQUEUE, 32'hffff_ffff));
      directed_q.push_back(make_op(MODE_ENQUEUE, 32'h5555_5555));
      directed_q.push_back(make_op(MODE_ENQUEUE, 32'haaaa_aaaa));
      repeat (6) directed_q.push_back(make_op(MODE_DEQUEUE, 32'hffff_ffff));
      directed_q.push_back(make_op(MODE_ENQUEUE, 32'd10));
      directed_q.push_back(make_op(MODE_DEQUEUE, 32'd0));
      directed_q.push_back(make_op(MODE_ENQUEUE, 32'd11));
      directed_q.push_back(make_op(MODE_ENQUEUE, 32'd12));
      directed_q.push_back(make_op(MODE_DEQUEUE, 32'd0));
      directed_q.push_back(make_op(MODE_ENQUEUE, 32'd13));
      repeat (3) directed_q.push_back(make_op(MODE_DEQUEUE, 32'd0));

      foreach (directed_q[i]) begin
         offer(directed_q[i]);
         idle_gap(1'b0);
      end
      wait_drained();

      // first fill past both stacks so items get dropped, then drain to empty,
      // then blocks of random bias
      blk = 0;
      while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         case (blk)
            0: begin
               enq_pct   = 97;
               block_len = 320;
            end
            1: begin
               enq_pct   = 3;
               block_len = 320;
            end
            default: begin
               case ($urandom_range(0, 4))
                  0:       enq_pct = 90;
                  1:       enq_pct = 70;
                  2:       enq_pct = 50;
                  3:       enq_pct = 30;
                  default: enq_pct = 10;
               endcase
               block_len = $urandom_range(40, 200);
            end
         endcase
         if (blk == 2) wait_drained();
         eager = ($urandom_range(0, 4) == 0);
         repeat (block_len) begin
            offer(random_op(enq_pct));
            idle_gap(eager);
         end
         blk++;
      end

      wait_drained();
      repeat (20) @(posedge clock);

      $display("two_stack_queue_tb: %0d items sent: %0d reads, %0d empty reads, %0d dropped",
               items_sent, read_count, empty_count, drop_count);
      $display("two_stack_queue_tb: %0d inbox-to-outbox transfers, %0d mismatches",
               transfer_count, mismatch_count);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("two_stack_queue_tb: clean");
      end else begin
         $display("two_stack_queue_tb: errors");
      end
      $finish;
   end

endmodule
